FILE: rtl/fnr_pkg.sv
// Shared types and constants for the facet normal repair block.
package fnr_pkg;

   typedef struct packed {
      logic signed [31:0] stored_nx;
      logic signed [31:0] stored_ny;
      logic signed [31:0] stored_nz;
      logic signed [31:0] v1_x;
      logic signed [31:0] v1_y;
      logic signed [31:0] v1_z;
      logic signed [31:0] v2_x;
      logic signed [31:0] v2_y;
      logic signed [31:0] v2_z;
      logic signed [31:0] v3_x;
      logic signed [31:0] v3_y;
      logic signed [31:0] v3_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic [1:0]         corner;
      logic               repaired;
      logic               last;
   } rsp_type;

   typedef struct packed {
      req_type     req;
      logic        repaired;
      logic [2:0]  neg;
      logic [30:0] ax;
      logic [30:0] ay;
      logic [30:0] az;
   } mid_type;

   localparam int unsigned ISQ_LAT = 32;
   localparam int unsigned FRONT_LAT = 9;
   localparam logic [16:0] THRESHOLD_RESET = 17'd6554;
   localparam logic        REG_REPAIR_THRESHOLD = 1'b0;
   localparam logic [1:0]  CORNER_FIRST = 2'd0;
   localparam logic [1:0]  CORNER_MID = 2'd1;
   localparam logic [1:0]  CORNER_LAST = 2'd2;

endpackage

FILE: rtl/fnr_front.sv
// Front pipeline: edge vectors, cross product, length test, scaling and squared sum.
module fnr_front
   import fnr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  req_type     in_req,
   input  logic [16:0] threshold,
   output logic        out_valid,
   output mid_type     out_mid,
   output logic [63:0] out_sum
);

   logic [FRONT_LAT-1:0] valid_ff;
   req_type              req_ff [FRONT_LAT];

   logic signed [32:0] d1_ff [3];
   logic signed [32:0] d2_ff [3];
   logic [63:0]        sq_ff [3];
   logic [33:0]        thr2_ff;
   logic [33:0]        thr2b_ff;
   logic signed [65:0] prod_ff [6];
   logic [65:0]        len2_ff;
   logic signed [66:0] cross_ff [3];
   logic               rep3_ff, rep4_ff, rep5_ff, rep6_ff, rep7_ff, rep8_ff, rep9_ff;
   logic [2:0]         neg4_ff, neg5_ff, neg6_ff, neg7_ff, neg8_ff, neg9_ff;
   logic [65:0]        mag4_ff [3];
   logic [65:0]        mag5_ff [3];
   logic [65:0]        mag6_ff [3];
   logic [65:0]        orm5_ff;
   logic [5:0]         shift6_ff;
   logic [30:0]        a7_ff [3];
   logic [30:0]        a8_ff [3];
   logic [30:0]        a9_ff [3];
   logic [61:0]        sq8_ff [3];
   logic [63:0]        sum9_ff;

   logic signed [32:0] v1s [3];
   logic signed [32:0] v2s [3];
   logic signed [32:0] v3s [3];
   logic signed [32:0] sns [3];
   logic [31:0]        snm [3];
   logic [6:0]         blen;
   logic [5:0]         shift_in;

   always_comb begin
      v1s[0] = 33'(in_req.v1_x); v1s[1] = 33'(in_req.v1_y); v1s[2] = 33'(in_req.v1_z);
      v2s[0] = 33'(in_req.v2_x); v2s[1] = 33'(in_req.v2_y); v2s[2] = 33'(in_req.v2_z);
      v3s[0] = 33'(in_req.v3_x); v3s[1] = 33'(in_req.v3_y); v3s[2] = 33'(in_req.v3_z);
      sns[0] = 33'(in_req.stored_nx);
      sns[1] = 33'(in_req.stored_ny);
      sns[2] = 33'(in_req.stored_nz);
      for (int i = 0; i < 3; i++) begin
         snm[i] = sns[i][32] ? 32'(-sns[i]) : 32'(sns[i]);
      end
   end

   always_comb begin
      blen = '0;
      for (int i = 0; i < 66; i++) begin
         if (orm5_ff[i]) begin
            blen = 7'(i + 1);
         end
      end
      shift_in = (blen > 7'd31) ? 6'(blen - 7'd31) : 6'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[FRONT_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      req_ff[0] <= in_req;
      for (int k = 1; k < FRONT_LAT; k++) begin
         req_ff[k] <= req_ff[k-1];
      end
      for (int i = 0; i < 3; i++) begin
         d1_ff[i] <= v2s[i] - v1s[i];
         d2_ff[i] <= v3s[i] - v1s[i];
         sq_ff[i] <= snm[i] * snm[i];
      end
      thr2_ff <= threshold * threshold;
      prod_ff[0] <= d1_ff[1] * d2_ff[2];
      prod_ff[1] <= d1_ff[2] * d2_ff[1];
      prod_ff[2] <= d1_ff[2] * d2_ff[0];
      prod_ff[3] <= d1_ff[0] * d2_ff[2];
      prod_ff[4] <= d1_ff[0] * d2_ff[1];
      prod_ff[5] <= d1_ff[1] * d2_ff[0];
      len2_ff  <= 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
      thr2b_ff <= thr2_ff;
      for (int i = 0; i < 3; i++) begin
         cross_ff[i] <= 67'(prod_ff[2*i]) - 67'(prod_ff[2*i+1]);
      end
      rep3_ff <= len2_ff < 66'(thr2b_ff);
      rep4_ff <= rep3_ff;
      for (int i = 0; i < 3; i++) begin
         neg4_ff[i] <= cross_ff[i][66];
         mag4_ff[i] <= cross_ff[i][66] ? 66'(-cross_ff[i]) : 66'(cross_ff[i]);
      end
      rep5_ff <= rep4_ff;
      neg5_ff <= neg4_ff;
      mag5_ff <= mag4_ff;
      orm5_ff <= mag4_ff[0] | mag4_ff[1] | mag4_ff[2];
      rep6_ff <= rep5_ff;
      neg6_ff <= neg5_ff;
      mag6_ff <= mag5_ff;
      shift6_ff <= shift_in;
      rep7_ff <= rep6_ff;
      neg7_ff <= neg6_ff;
      for (int i = 0; i < 3; i++) begin
         a7_ff[i] <= 31'(mag6_ff[i] >> shift6_ff);
      end
      rep8_ff <= rep7_ff;
      neg8_ff <= neg7_ff;
      a8_ff   <= a7_ff;
      for (int i = 0; i < 3; i++) begin
         sq8_ff[i] <= a7_ff[i] * a7_ff[i];
      end
      rep9_ff <= rep8_ff;
      neg9_ff <= neg8_ff;
      a9_ff   <= a8_ff;
      sum9_ff <= 64'(sq8_ff[0]) + 64'(sq8_ff[1]) + 64'(sq8_ff[2]);
   end

   assign out_valid        = valid_ff[FRONT_LAT-1];
   assign out_mid.req      = req_ff[FRONT_LAT-1];
   assign out_mid.repaired = rep9_ff;
   assign out_mid.neg      = neg9_ff;
   assign out_mid.ax       = a9_ff[0];
   assign out_mid.ay       = a9_ff[1];
   assign out_mid.az       = a9_ff[2];
   assign out_sum          = sum9_ff;

endmodule

FILE: rtl/fnr_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module fnr_isqrt
   import fnr_pkg::*;
(
   input  logic        clock,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   logic [33:0] rem_ff  [ISQ_LAT];
   logic [31:0] root_ff [ISQ_LAT];
   logic [63:0] rest_ff [ISQ_LAT];
   logic [33:0] rem_in  [ISQ_LAT];
   logic [31:0] root_in [ISQ_LAT];
   logic [63:0] rest_in [ISQ_LAT];
   logic [33:0] rem_s   [ISQ_LAT+1];
   logic [31:0] root_s  [ISQ_LAT+1];
   logic [63:0] rest_s  [ISQ_LAT+1];

   assign rem_s[0]  = '0;
   assign root_s[0] = '0;
   assign rest_s[0] = radicand;

   for (genvar k = 0; k < ISQ_LAT; k++) begin : g_stage
      logic [33:0] r4;
      logic [33:0] trial;
      logic        ge;
      always_comb begin
         r4         = {rem_s[k][31:0], rest_s[k][63:62]};
         trial      = {root_s[k], 2'b01};
         ge         = r4 >= trial;
         rem_in[k]  = ge ? r4 - trial : r4;
         root_in[k] = {root_s[k][30:0], ge};
         rest_in[k] = {rest_s[k][61:0], 2'b00};
      end
      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         rest_ff[k] <= rest_in[k];
      end
      assign rem_s[k+1]  = rem_ff[k];
      assign root_s[k+1] = root_ff[k];
      assign rest_s[k+1] = rest_ff[k];
   end

   assign root = root_s[ISQ_LAT];

endmodule

FILE: rtl/fnr_div.sv
// Pipelined restoring divider giving a rounded unit-scale normal component.
module fnr_div #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic [30:0]          numer,
   input  logic [31:0]          denom,
   output logic [FRAC_BITS:0]   quot
);

   localparam int unsigned QW = FRAC_BITS + 1;
   localparam int unsigned NW = 32 + FRAC_BITS;

   logic [NW-1:0] n_ff;
   logic [31:0]   den_ff [QW+1];
   logic [32:0]   rem_ff [QW+1];
   logic [QW-1:0] low_ff [QW+1];
   logic [QW-1:0] q_ff   [QW+1];

   always_ff @(posedge clock) begin
      n_ff      <= {1'b0, numer, {FRAC_BITS{1'b0}}} + NW'(denom[31:1]);
      den_ff[0] <= denom;
   end

   always_comb begin
      rem_ff[0] = 33'(n_ff[NW-1:QW]);
      low_ff[0] = n_ff[QW-1:0];
      q_ff[0]   = '0;
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [32:0] t;
      logic        ge;
      always_comb begin
         t  = {rem_ff[k][31:0], low_ff[k][QW-1]};
         ge = t >= 33'(den_ff[k]);
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? t - 33'(den_ff[k]) : t;
         low_ff[k+1] <= {low_ff[k][QW-2:0], 1'b0};
         q_ff[k+1]   <= {q_ff[k][QW-2:0], ge};
         den_ff[k+1] <= den_ff[k];
      end
   end

   assign quot = (den_ff[QW] == '0) ? '0 : q_ff[QW];

endmodule

FILE: rtl/facet_normal_repair_top.sv
// Top level of the facet normal repair block: register port, pipeline and record output.
// Each facet gives three records on consecutive cycles, corner 0 first.
// A new request is accepted only while busy is low, which spaces facets for the single record output.
// busy is raised by each accepted request and falls when its gap counter reaches zero.
// Reset clears all valid bits and sets repair_threshold to 6554; results cannot be stalled.
module facet_normal_repair_top
   import fnr_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned QW = FRAC_BITS + 1;
   localparam int unsigned DIV_LAT = QW + 1;

   logic [16:0] thr_ff;
   logic [1:0]  gap_ff;
   logic        in_valid_ff;
   req_type     in_req_ff;

   logic        front_valid;
   mid_type     front_mid;
   logic [63:0] front_sum;
   logic [31:0] root;

   logic [ISQ_LAT-1:0] v1_ff;
   mid_type            m1_ff [ISQ_LAT];
   logic [DIV_LAT-1:0] v2_ff;
   mid_type            m2_ff [DIV_LAT];
   logic [QW-1:0]      q [3];

   logic        end_valid;
   mid_type     end_mid;
   logic [31:0] nrm [3];
   logic        active_ff, active_in;
   logic [1:0]  corner_ff, corner_in;
   mid_type     facet_ff, facet_in;
   logic [31:0] fn_ff [3];
   logic [31:0] fn_in [3];
   rsp_type     rsp_ff, rsp_in;
   logic        accept;

   assign accept = start && !busy;
   assign busy   = gap_ff != 2'd0;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_REPAIR_THRESHOLD) ? 32'(thr_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THRESHOLD_RESET;
         gap_ff      <= 2'd0;
         in_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_REPAIR_THRESHOLD) begin
            thr_ff <= pwdata[16:0];
         end
         gap_ff      <= accept ? 2'd2 : (busy ? gap_ff - 2'd1 : 2'd0);
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff <= req_data;
      end
   end

   fnr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_req    (in_req_ff),
      .threshold (thr_ff),
      .out_valid (front_valid),
      .out_mid   (front_mid),
      .out_sum   (front_sum)
   );

   fnr_isqrt u_isqrt (
      .clock    (clock),
      .radicand (front_sum),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
         v2_ff <= '0;
      end else begin
         v1_ff <= {v1_ff[ISQ_LAT-2:0], front_valid};
         v2_ff <= {v2_ff[DIV_LAT-2:0], v1_ff[ISQ_LAT-1]};
      end
   end

   always_ff @(posedge clock) begin
      m1_ff[0] <= front_mid;
      for (int k = 1; k < ISQ_LAT; k++) begin
         m1_ff[k] <= m1_ff[k-1];
      end
      m2_ff[0] <= m1_ff[ISQ_LAT-1];
      for (int k = 1; k < DIV_LAT; k++) begin
         m2_ff[k] <= m2_ff[k-1];
      end
   end

   fnr_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock), .numer (m1_ff[ISQ_LAT-1].ax), .denom (root), .quot (q[0])
   );
   fnr_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock), .numer (m1_ff[ISQ_LAT-1].ay), .denom (root), .quot (q[1])
   );
   fnr_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
      .clock (clock), .numer (m1_ff[ISQ_LAT-1].az), .denom (root), .quot (q[2])
   );

   assign end_valid = v2_ff[DIV_LAT-1];
   assign end_mid   = m2_ff[DIV_LAT-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm[i] = end_mid.neg[i] ? 32'd0 - 32'(q[i]) : 32'(q[i]);
      end
      if (!end_mid.repaired) begin
         nrm[0] = end_mid.req.stored_nx;
         nrm[1] = end_mid.req.stored_ny;
         nrm[2] = end_mid.req.stored_nz;
      end
      facet_in  = end_valid ? end_mid : facet_ff;
      for (int i = 0; i < 3; i++) begin
         fn_in[i] = end_valid ? nrm[i] : fn_ff[i];
      end
      corner_in = end_valid ? CORNER_FIRST : corner_ff + 2'd1;
      active_in = end_valid || (active_ff && corner_ff != CORNER_LAST);
      rsp_in.norm_x   = fn_in[0];
      rsp_in.norm_y   = fn_in[1];
      rsp_in.norm_z   = fn_in[2];
      rsp_in.corner   = corner_in;
      rsp_in.repaired = facet_in.repaired;
      rsp_in.last     = corner_in == CORNER_LAST;
      case (corner_in)
         CORNER_FIRST: begin
            rsp_in.pos_x = facet_in.req.v1_x;
            rsp_in.pos_y = facet_in.req.v1_y;
            rsp_in.pos_z = facet_in.req.v1_z;
         end
         CORNER_MID: begin
            rsp_in.pos_x = facet_in.req.v2_x;
            rsp_in.pos_y = facet_in.req.v2_y;
            rsp_in.pos_z = facet_in.req.v2_z;
         end
         default: begin
            rsp_in.pos_x = facet_in.req.v3_x;
            rsp_in.pos_y = facet_in.req.v3_y;
            rsp_in.pos_z = facet_in.req.v3_z;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      corner_ff <= corner_in;
      facet_ff  <= facet_in;
      fn_ff     <= fn_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = active_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after request");

   a_corner_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.corner == CORNER_FIRST |=> rsp_valid && rsp_data.corner == CORNER_MID)
      else $error("record sequence broken");

   a_last_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.corner == CORNER_MID |=> rsp_valid && rsp_data.last)
      else $error("last record missing");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      end_valid |-> !active_ff || corner_ff == CORNER_LAST)
      else $error("facet arrived while records pending");
`endif

endmodule

FILE: bench/facet_normal_repair_top_test.sv
// Self-checking bench for facet_normal_repair_top: directed facets, then random facets per threshold.
module facet_normal_repair_top_test
   import fnr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAC = 16;
   localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
   localparam logic [2:0] ADDR_UNUSED = 3'd4;
   localparam int unsigned LATENCY = 44 + FRAC;
   localparam logic signed [31:0] ONE = 32'sd65536;
   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;

   typedef struct {
      req_type            facet;
      bit                 typed;
      logic signed [31:0] nx, ny, nz;
      bit                 rep;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic [16:0] threshold = THRESHOLD_RESET;
   rsp_type     pending_records[$];
   int          errors = 0;
   row_type     directed[$];

   facet_normal_repair_top #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   initial begin
      #2ms;
      $display("facet_normal_repair_top: mismatch");
      $finish;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s got %h expected %h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   task automatic choose_normal(input req_type f, output logic signed [31:0] n[3],
                                output bit rep);
      logic signed [69:0] d1[3], d2[3], cr[3];
      logic [69:0]        mg[3];
      logic [63:0]        a[3], sum, r, q, len2, thr2;
      logic signed [31:0] sn[3];
      int                 maxbits, sh;
      sn[0] = f.stored_nx; sn[1] = f.stored_ny; sn[2] = f.stored_nz;
      len2 = 0;
      for (int i = 0; i < 3; i++) len2 += 64'(64'(sn[i]) * 64'(sn[i]));
      thr2 = 64'(threshold) * 64'(threshold);
      rep = len2 < thr2;
      if (!rep) begin
         n = sn;
         return;
      end
      d1[0] = f.v2_x - f.v1_x; d1[1] = f.v2_y - f.v1_y; d1[2] = f.v2_z - f.v1_z;
      d2[0] = f.v3_x - f.v1_x; d2[1] = f.v3_y - f.v1_y; d2[2] = f.v3_z - f.v1_z;
      for (int i = 0; i < 3; i++) begin
         d1[i] = $signed({{38{1'b0}}, 32'b0}) + d1[i];
      end
      d1[0] = 70'(f.v2_x) - 70'(f.v1_x); d1[1] = 70'(f.v2_y) - 70'(f.v1_y);
      d1[2] = 70'(f.v2_z) - 70'(f.v1_z);
      d2[0] = 70'(f.v3_x) - 70'(f.v1_x); d2[1] = 70'(f.v3_y) - 70'(f.v1_y);
      d2[2] = 70'(f.v3_z) - 70'(f.v1_z);
      cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
      cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
      cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
      maxbits = 0;
      for (int i = 0; i < 3; i++) begin
         mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
         for (int b = 0; b < 70; b++) if (mg[i][b] && b + 1 > maxbits) maxbits = b + 1;
      end
      sh = maxbits > 31 ? maxbits - 31 : 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = 64'(mg[i] >> sh);
         sum += a[i] * a[i];
      end
      r = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = r == 0 ? 64'd0 : ((a[i] << FRAC) + (r >> 1)) / r;
         if (cr[i] < 0) q = -q;
         n[i] = q[31:0];
      end
   endtask

   task automatic expect_records(input req_type f, input bit typed,
                                 input logic signed [31:0] tn[3], input bit trep);
      logic signed [31:0] n[3];
      bit                 rep;
      rsp_type            rec;
      if (typed) begin
         n = tn;
         rep = trep;
      end else begin
         choose_normal(f, n, rep);
      end
      for (int k = 0; k < 3; k++) begin
         case (k)
            0: begin rec.pos_x = f.v1_x; rec.pos_y = f.v1_y; rec.pos_z = f.v1_z; end
            1: begin rec.pos_x = f.v2_x; rec.pos_y = f.v2_y; rec.pos_z = f.v2_z; end
            default: begin rec.pos_x = f.v3_x; rec.pos_y = f.v3_y; rec.pos_z = f.v3_z; end
         endcase
         rec.norm_x = n[0]; rec.norm_y = n[1]; rec.norm_z = n[2];
         rec.corner = k == 0 ? CORNER_FIRST : (k == 1 ? CORNER_MID : CORNER_LAST);
         rec.repaired = rep;
         rec.last = k == 2;
         pending_records.push_back(rec);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_records.size() == 0) begin
            report_mismatch("unexpected record", rsp_data.pos_x, 0);
         end else begin
            want = pending_records.pop_front();
            if (rsp_data.pos_x !== want.pos_x) report_mismatch("pos_x", rsp_data.pos_x, want.pos_x);
            if (rsp_data.pos_y !== want.pos_y) report_mismatch("pos_y", rsp_data.pos_y, want.pos_y);
            if (rsp_data.pos_z !== want.pos_z) report_mismatch("pos_z", rsp_data.pos_z, want.pos_z);
            if (rsp_data.norm_x !== want.norm_x)
               report_mismatch("norm_x", rsp_data.norm_x, want.norm_x);
            if (rsp_data.norm_y !== want.norm_y)
               report_mismatch("norm_y", rsp_data.norm_y, want.norm_y);
            if (rsp_data.norm_z !== want.norm_z)
               report_mismatch("norm_z", rsp_data.norm_z, want.norm_z);
            if (rsp_data.corner !== want.corner)
               report_mismatch("corner", 32'(rsp_data.corner), 32'(want.corner));
            if (rsp_data.repaired !== want.repaired)
               report_mismatch("repaired", 32'(rsp_data.repaired), 32'(want.repaired));
            if (rsp_data.last !== want.last)
               report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
         end
      end
   end

   task automatic csr_access(input logic [2:0] addr, input bit wr, input logic [31:0] data,
                             output logic [31:0] rd);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_threshold(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] rd;
      csr_access(addr, 1'b1, value, rd);
      if (addr == ADDR_THRESHOLD) threshold = value[16:0];
      csr_access(ADDR_THRESHOLD, 1'b0, 0, rd);
      if (rd[16:0] !== threshold) report_mismatch("threshold readback", rd, 32'(threshold));
   endtask

   task automatic send_facet(input req_type f, input bit typed,
                             input logic signed [31:0] tn[3], input bit trep);
      int gap;
      start <= 1'b1;
      req_data <= f;
      @(posedge clock);
      while (busy) @(posedge clock);
      expect_records(f, typed, tn, trep);
      gap = $urandom_range(0, 99);
      if (gap < 55) gap = 0;
      else if (gap < 92) gap = $urandom_range(1, 4);
      else gap = $urandom_range(10, 80);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         1: return $urandom_range(0, 1) ? MAXV - $urandom_range(0, 3)
                                        : MINV + $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_facet();
      req_type f;
      int      nm, vm;
      nm = $urandom_range(0, 9);
      vm = $urandom_range(0, 9);
      vm = vm < 6 ? 0 : (vm < 8 ? 2 : 1);
      f.v1_x = rand_coord(vm); f.v1_y = rand_coord(vm); f.v1_z = rand_coord(vm);
      f.v2_x = rand_coord(vm); f.v2_y = rand_coord(vm); f.v2_z = rand_coord(vm);
      f.v3_x = rand_coord(vm); f.v3_y = rand_coord(vm); f.v3_z = rand_coord(vm);
      if ($urandom_range(0, 19) == 0) f.v3_x = f.v2_x;
      if ($urandom_range(0, 19) == 0) begin
         f.v2_x = f.v1_x; f.v2_y = f.v1_y; f.v2_z = f.v1_z;
      end
      if (nm < 2) begin
         f.stored_nx = 0; f.stored_ny = 0; f.stored_nz = 0;
      end else if (nm < 7) begin
         f.stored_nx = 32'(int'($urandom_range(0, 160000)) - 80000);
         f.stored_ny = 32'(int'($urandom_range(0, 160000)) - 80000);
         f.stored_nz = 32'(int'($urandom_range(0, 160000)) - 80000);
      end else begin
         f.stored_nx = $urandom; f.stored_ny = $urandom; f.stored_nz = $urandom;
      end
      return f;
   endfunction

   function automatic row_type make_row(logic signed [31:0] s0, s1, s2,
                                        logic signed [31:0] a0, a1, a2,
                                        logic signed [31:0] b0, b1, b2,
                                        logic signed [31:0] c0, c1, c2,
                                        bit typed, logic signed [31:0] nx, ny, nz, bit rep);
      row_type r;
      r.facet = '{s0, s1, s2, a0, a1, a2, b0, b1, b2, c0, c1, c2};
      r.typed = typed;
      r.nx = nx; r.ny = ny; r.nz = nz;
      r.rep = rep;
      return r;
   endfunction

   initial begin
      logic signed [31:0] tn[3];
      logic [31:0]        thr_set[$];
      logic [31:0]        rd;
      int                 count;
      directed.push_back(make_row(ONE, 0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 1, ONE, 0, 0, 0));
      directed.push_back(make_row(0, 0, 0, 5, 5, 5, 5, 5, 5, 5, 5, 5, 1, 0, 0, 0, 1));
      directed.push_back(make_row(0, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1, 0, 0, ONE, 1));
      directed.push_back(make_row(0, 0, 0, 0, 0, 0, 0, ONE, 0, ONE, 0, 0, 1, 0, 0, -ONE, 1));
      directed.push_back(make_row(MAXV, MAXV, MAXV, 0, 0, 0, 1, 0, 0, 0, 1, 0,
                                  1, MAXV, MAXV, MAXV, 0));
      directed.push_back(make_row(MINV, MINV, MINV, 0, 0, 0, 1, 0, 0, 0, 1, 0,
                                  1, MINV, MINV, MINV, 0));
      directed.push_back(make_row(6554, 0, 0, 0, 0, 0, 0, 0, ONE, ONE, 0, 0,
                                  1, 6554, 0, 0, 0));
      directed.push_back(make_row(6553, 0, 0, 0, 0, 0, 0, 0, ONE, ONE, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_row(0, 0, -6553, MINV, MINV, MINV, MAXV, MAXV, MAXV,
                                  MAXV, MINV, MAXV, 0, 0, 0, 0, 0));
      directed.push_back(make_row(0, 0, 0, MAXV, MINV, MAXV, MINV, MAXV, MINV,
                                  MINV, MINV, MAXV, 0, 0, 0, 0, 0));
      directed.push_back(make_row(0, 0, 0, MINV, 0, 0, MAXV, 0, 0, 0, MAXV, MINV,
                                  0, 0, 0, 0, 0));
      directed.push_back(make_row(-3, 2, 1, 123456, -98765, 4321, -55555, 777777, -1,
                                  9, 8, -700000, 0, 0, 0, 0, 0));
      directed.push_back(make_row(0, 0, 0, 0, 0, 0, 3, 0, 0, 6, 0, 0, 1, 0, 0, 0, 1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(ADDR_THRESHOLD, 1'b0, 0, rd);
      if (rd[16:0] !== THRESHOLD_RESET)
         report_mismatch("threshold reset", rd, 32'(THRESHOLD_RESET));

      foreach (directed[i]) begin
         tn[0] = directed[i].nx; tn[1] = directed[i].ny; tn[2] = directed[i].nz;
         send_facet(directed[i].facet, directed[i].typed, tn, directed[i].rep);
      end
      drain();

      thr_set = '{0, 32'd131071, 32'd65536, $urandom_range(1, 131071),
                  32'hfffe0000 | $urandom_range(0, 131071), $urandom_range(0, 8000)};
      foreach (thr_set[p]) begin
         set_threshold(ADDR_THRESHOLD, thr_set[p]);
         if (p == 2) set_threshold(ADDR_UNUSED, 32'd1);
         count = 0;
         while (count < 62) begin
            if (p == 3 && count == 30) drain();
            send_facet(rand_facet(), 1'b0, tn, 1'b0);
            count++;
         end
         drain();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && pending_records.size() == 0) begin
         $display("facet_normal_repair_top: match");
      end else begin
         $display("facet_normal_repair_top: mismatch");
      end
      $finish;
   end

endmodule
